>>> hw/rtl/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared operation codes, status codes and controller command type for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int OP_W  = 3;
  localparam int ST_W  = 2;
  localparam int POS_W = 8;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_GET        = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic accept;     // latch the input word
    logic exec;       // apply the operation: pointers, count, store write
    logic sel_target; // read port A at the pop/get target, else at the front
    logic capture;    // hold the pop/get read data
    logic load_out;   // load the result register
  } dq_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue over a ring store: push/pop at either end,
// indexed get and clear, one result word per input word.
// ----------------------------------------------------------------------------
// Sequencing: input accept, then store write and target read, then a
//   registered read of the new front and back, then result load (stalls on
//   out_stall); a new word is accepted only after the result is loaded.
// Reset: synchronous, clears front pointer, count and handshake state; the
//   queue is empty right after reset and the store is not swept.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [dq_pkg::OP_W-1:0]      in_mode,
  input  wire logic [DATA_WIDTH-1:0]        in_data_in,
  input  wire logic [dq_pkg::POS_W-1:0]     in_position,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [DATA_WIDTH-1:0]        out_data_out,
  output logic      [dq_pkg::ST_W-1:0]      out_status,
  output logic      [$clog2(DEPTH+1)-1:0]   out_count,
  output logic                              out_empty,
  output logic      [DATA_WIDTH-1:0]        out_front_word,
  output logic      [DATA_WIDTH-1:0]        out_back_word
);
  import dq_pkg::*;

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_data_in     (in_data_in),
    .in_position    (in_position),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_empty      (out_empty),
    .out_front_word (out_front_word),
    .out_back_word  (out_back_word)
  );

endmodule
`default_nettype wire

>>> hw/rtl/dq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

>>> hw/rtl/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: accept, execute, fetch front/back, deliver result word.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take a new word when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.sel_target = 1'b1;
        state_nxt      = S_FETCH;
      end
      S_FETCH: begin
        cmd.capture = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/dq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_dp
// Datapath: ring pointers, entry count, ring store and result register.
// ----------------------------------------------------------------------------
module dq_dp #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dq_pkg::dq_cmd_t              cmd,
  input  wire logic [dq_pkg::OP_W-1:0]      in_mode,
  input  wire logic [DATA_WIDTH-1:0]        in_data_in,
  input  wire logic [dq_pkg::POS_W-1:0]     in_position,
  output logic      [DATA_WIDTH-1:0]        out_data_out,
  output logic      [dq_pkg::ST_W-1:0]      out_status,
  output logic      [$clog2(DEPTH+1)-1:0]   out_count,
  output logic                              out_empty,
  output logic      [DATA_WIDTH-1:0]        out_front_word,
  output logic      [DATA_WIDTH-1:0]        out_back_word
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // sum width: holds front + count or front + position without overflow
  localparam int SW = ((AW > POS_W) ? AW : POS_W) + 1;

  // latched input word
  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [POS_W-1:0]      pos_r;

  // queue state
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // per-item results
  logic [ST_W-1:0]       status_r, status_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [DATA_WIDTH-1:0] rd_r;

  // result register
  logic [DATA_WIDTH-1:0] o_data_r, o_front_r, o_back_r;
  logic [ST_W-1:0]       o_status_r;
  logic [CW-1:0]         o_count_r;
  logic                  o_empty_r;

  logic                  full, empty;
  logic [AW-1:0]         front_dec, front_inc, back_addr, tail_addr, get_addr;
  logic [AW-1:0]         raddr_a, waddr;
  logic                  we;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return r[AW-1:0];
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = wrap(SW'(front_r) + SW'(1));
  assign back_addr = wrap(SW'(front_r) + SW'(count_r) - SW'(1));
  assign tail_addr = wrap(SW'(front_r) + SW'(count_r));
  assign get_addr  = wrap(SW'(front_r) + SW'(pos_r));

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_ok_nxt  = 1'b0;
    we         = 1'b0;
    waddr      = tail_addr;
    raddr_a    = front_r;
    case (op_r)
      OP_PUSH_FRONT: begin
        waddr = front_dec;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_ok_nxt = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        raddr_a = back_addr;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_ok_nxt = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_GET: begin
        raddr_a = get_addr;
        // position may be wider than the count, compare in the sum width
        if (SW'(pos_r) >= SW'(count_r)) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      OP_CLEAR: count_nxt = '0;
      default: ;
    endcase
    // after execute, port A points at the (new) front
    if (!cmd.sel_target) begin
      raddr_a = front_r;
    end
    if (!cmd.exec) begin
      we = 1'b0;
    end
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (data_r),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (back_addr),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_mode;
      data_r <= in_data_in;
      pos_r  <= in_position;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
    if (cmd.capture) begin
      rd_r <= rdata_a;
    end
    if (cmd.load_out) begin
      o_data_r   <= rd_ok_r ? rd_r : '0;
      o_status_r <= status_r;
      o_count_r  <= count_r;
      o_empty_r  <= empty;
      o_front_r  <= empty ? '0 : rdata_a;
      o_back_r   <= empty ? '0 : rdata_b;
    end
  end

  assign out_data_out   = o_data_r;
  assign out_status     = o_status_r;
  assign out_count      = o_count_r;
  assign out_empty      = o_empty_r;
  assign out_front_word = o_front_r;
  assign out_back_word  = o_back_r;

endmodule
`default_nettype wire
